/* rtl/gsls_pkg.sv */
// Shared types and constants of the golden-section line-search unit.
`timescale 1ns / 1ps

package gsls_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // 2/(sqrt(5)+3) as unsigned Q0.32
    localparam logic [63:0] ETA_Q32      = 64'h0000_0000_61C8_8647;
    localparam logic [63:0] ROUND_HALF   = 64'h0000_0000_8000_0000;
    localparam logic [30:0] WIDTH_MAX31  = 31'h7FFF_FFFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    typedef enum logic [1:0] {
        REG_INTERVAL_LEFT   = 2'd0,
        REG_INTERVAL_RIGHT  = 2'd1,
        REG_TOLERANCE       = 2'd2,
        REG_ITERATION_LIMIT = 2'd3
    } reg_addr_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] objective_value;
    } cmd_t;

    typedef struct packed {
        logic               done_res;
        logic signed [31:0] position;
        logic [15:0]        iterations_used;
        logic [30:0]        final_width;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] interval_left;
        logic signed [31:0] interval_right;
        logic [30:0]        tolerance;
        logic [15:0]        iteration_limit;
    } cfg_t;

    // Input stage contents: the command plus the ordered interval of a start
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] objective_value;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        width;
    } stage_t;

endpackage

/* rtl/gsls_cfg.sv */
// APB register file of the golden-section line-search unit.
`timescale 1ns / 1ps

module gsls_cfg
    import gsls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    reg_addr_t reg_sel;
    logic      wr_en;

    assign reg_sel = reg_addr_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_INTERVAL_LEFT:   cfg_next.interval_left   = $signed(pwdata);
                REG_INTERVAL_RIGHT:  cfg_next.interval_right  = $signed(pwdata);
                REG_TOLERANCE:       cfg_next.tolerance       = pwdata[30:0];
                REG_ITERATION_LIMIT: cfg_next.iteration_limit = pwdata[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_INTERVAL_LEFT:   prdata = cfg_reg.interval_left;
            REG_INTERVAL_RIGHT:  prdata = cfg_reg.interval_right;
            REG_TOLERANCE:       prdata = {1'b0, cfg_reg.tolerance};
            REG_ITERATION_LIMIT: prdata = {16'd0, cfg_reg.iteration_limit};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_left   <= 32'sh0000_0000;
            cfg_reg.interval_right  <= 32'sh0003_0000;
            cfg_reg.tolerance       <= 31'd7;
            cfg_reg.iteration_limit <= 16'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/gsls_core.sv */
// Bracket state and combinational narrowing step of the line search.
`timescale 1ns / 1ps

module gsls_core
    import gsls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   fire,
    input  stage_t stage,
    input  cfg_t   cfg,
    output logic   emit,
    output rsp_t   result
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FIRST = 3'b010,
        PH_RUN   = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               pending_reg, pending_next;
    logic [15:0]        count_reg, count_next;
    logic signed [31:0] inner_left_reg, inner_left_next;
    logic signed [31:0] inner_right_reg, inner_right_next;
    logic [31:0]        width_reg, width_next;
    logic signed [31:0] val_left_reg, val_left_next;
    logic signed [31:0] val_right_reg, val_right_next;

    logic [31:0]        mul_in;
    logic [63:0]        product;
    logic [31:0]        step;
    logic signed [33:0] step_ext;
    logic signed [31:0] start_left;
    logic signed [31:0] start_right;
    logic signed [31:0] val_left_cur;
    logic signed [31:0] val_right_cur;
    logic               drop_right;
    logic signed [31:0] shift_left;
    logic signed [31:0] shift_right;
    logic signed [31:0] il_new;
    logic signed [31:0] ir_new;
    logic signed [31:0] req_pos;
    logic [31:0]        width_new;
    logic [15:0]        count_inc;
    logic               limit_hit;
    logic               tol_hit;
    logic               limit_hit_inc;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            r = v[31:0];
        else if (v[33])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    function automatic logic [30:0] width_sat(input logic [31:0] w);
        return w[31] ? WIDTH_MAX31 : w[30:0];
    endfunction

    // One multiplier serves the start and the narrowing step
    assign mul_in   = (stage.opcode == OP_START) ? stage.width : width_reg;
    assign product  = 64'(mul_in) * ETA_Q32 + ROUND_HALF;
    assign step     = product[63:32];
    assign step_ext = $signed({2'b00, step});

    assign start_left  = sat32(sext34(stage.lo) + step_ext);
    assign start_right = sat32(sext34(stage.hi) - step_ext);

    assign val_left_cur  = pending_reg ? val_left_reg : stage.objective_value;
    assign val_right_cur = pending_reg ? stage.objective_value : val_right_reg;
    assign drop_right    = val_left_cur < val_right_cur;

    assign shift_left  = sat32(sext34(inner_right_reg) - step_ext);
    assign shift_right = sat32(sext34(inner_left_reg) + step_ext);
    assign il_new      = drop_right ? shift_left : inner_right_reg;
    assign ir_new      = drop_right ? inner_left_reg : shift_right;
    assign req_pos     = drop_right ? il_new : ir_new;

    assign width_new     = width_reg - step;
    assign count_inc     = count_reg + 16'd1;
    assign limit_hit     = count_reg >= cfg.iteration_limit;
    assign tol_hit       = width_new < {1'b0, cfg.tolerance};
    assign limit_hit_inc = count_inc >= cfg.iteration_limit;

    always_comb
    begin
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        count_next       = count_reg;
        inner_left_next  = inner_left_reg;
        inner_right_next = inner_right_reg;
        width_next       = width_reg;
        val_left_next    = val_left_reg;
        val_right_next   = val_right_reg;
        emit             = 1'b0;
        result           = '0;

        if (fire)
        begin
            if (stage.opcode == OP_START)
            begin
                inner_left_next  = start_left;
                inner_right_next = start_right;
                width_next       = stage.width;
                val_left_next    = '0;
                val_right_next   = '0;
                count_next       = '0;
                pending_next     = 1'b0;
                phase_next       = PH_FIRST;
                emit             = 1'b1;
                result.position  = start_left;
            end
            else
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        val_left_next   = stage.objective_value;
                        pending_next    = 1'b1;
                        phase_next      = PH_RUN;
                        emit            = 1'b1;
                        result.position = inner_right_reg;
                    end
                    PH_RUN:
                    begin
                        emit           = 1'b1;
                        val_left_next  = val_left_cur;
                        val_right_next = val_right_cur;
                        if (limit_hit)
                        begin
                            phase_next             = PH_IDLE;
                            result.done_res        = 1'b1;
                            result.position        = inner_left_reg;
                            result.iterations_used = count_reg;
                            result.final_width     = width_sat(width_reg);
                        end
                        else
                        begin
                            inner_left_next  = il_new;
                            inner_right_next = ir_new;
                            pending_next     = ~drop_right;
                            width_next       = width_new;
                            if (drop_right)
                                val_right_next = val_left_cur;
                            else
                                val_left_next = val_right_cur;
                            if (tol_hit)
                            begin
                                phase_next             = PH_IDLE;
                                result.done_res        = 1'b1;
                                result.position        = il_new;
                                result.iterations_used = count_reg;
                                result.final_width     = width_sat(width_new);
                            end
                            else
                            begin
                                count_next = count_inc;
                                if (limit_hit_inc)
                                begin
                                    phase_next             = PH_IDLE;
                                    result.done_res        = 1'b1;
                                    result.position        = il_new;
                                    result.iterations_used = count_inc;
                                    result.final_width     = width_sat(width_new);
                                end
                                else
                                begin
                                    result.position = req_pos;
                                end
                            end
                        end
                    end
                    PH_IDLE:
                    begin
                        emit = 1'b0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pending_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inner_left_reg  <= inner_left_next;
        inner_right_reg <= inner_right_next;
        width_reg       <= width_next;
        val_left_reg    <= val_left_next;
        val_right_reg   <= val_right_next;
    end

    a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.done_res) |=> (phase_reg == PH_IDLE))
        else $error("search finished but phase did not return to idle");

    a_request_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !result.done_res) |-> (result.iterations_used == '0 &&
                                         result.final_width == '0))
        else $error("probe request carries nonzero finish fields");

    a_width_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stage.opcode == OP_VALUE && phase_reg == PH_RUN)
        |=> (width_reg <= $past(width_reg)))
        else $error("bracket width grew on a narrowing step");

endmodule

/* rtl/golden_section_line_search_unit.sv */
// Top level of the golden-section line-search unit.
`timescale 1ns / 1ps

// Golden-section line search in Q16.16, driven by an outside evaluator.
// Command channel (cmd_valid/cmd_stall/cmd): opcode start loads the interval
// from the registers; opcode value returns the objective at the last probe.
// Response channel (rsp_valid/rsp_stall/rsp): a probe request (done_res low)
// or the final answer with iteration count and bracket width (done_res high).
// A value that arrives while no search runs produces no response.
// A transfer happens at a clock edge with valid high and stall low.
// Throughput: one command per cycle while the receiver does not stall.
// Each command passes an input register, compare/subtract/multiply logic
// with a single 32x32 multiplier, and the response register.
// While the receiver stalls, the response holds; one more command is taken
// into the input register, then cmd_stall rises until the response leaves.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12; write them
// only while no search is in flight.
// Reset clears the registers to their defaults, empties both stages and
// returns the search to idle.

module golden_section_line_search_unit
    import gsls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_t                  cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t   cfg;
    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_reg, s1_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;
    logic   accept;
    logic   proceed;
    logic   emit;
    rsp_t   result;
    logic   swap;

    gsls_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsls_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (proceed),
        .stage  (s1_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (result)
    );

    assign proceed   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = s1_valid_reg && !proceed;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign swap = cfg.interval_left > cfg.interval_right;

    always_comb
    begin
        s1_next                 = s1_reg;
        s1_next.opcode          = cmd.opcode;
        s1_next.objective_value = cmd.objective_value;
        s1_next.lo              = swap ? cfg.interval_right : cfg.interval_left;
        s1_next.hi              = swap ? cfg.interval_left : cfg.interval_right;
        s1_next.width           = s1_next.hi - s1_next.lo;

        if (accept)
            s1_valid_next = 1'b1;
        else if (proceed)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        rsp_next = rsp_reg;
        if (proceed)
        begin
            rsp_valid_next = emit;
            if (emit)
                rsp_next = result;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        rsp_reg <= rsp_next;
    end

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg)
        else $error("command stalled with an empty input stage");

    a_free_path_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !rsp_valid_reg) |-> !cmd_stall)
        else $error("command stalled while the response register was free");

    a_rsp_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(proceed && emit))
        else $error("response appeared without a processed command");

endmodule

/* verif/golden_section_line_search_unit_test.sv */
// Self-checking bench for the golden-section line-search unit: directed table, random searches.
`timescale 1ns / 1ps

module golden_section_line_search_unit_test;
    import gsls_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 60;
    localparam longint POS_MAX    = 64'sd2147483647;
    localparam longint POS_MIN    = -64'sd2147483648;

    typedef enum logic [1:0] {
        SRCH_IDLE  = 2'd0,
        SRCH_FIRST = 2'd1,
        SRCH_RUN   = 2'd2
    } search_phase_e;

    typedef enum logic [1:0] {
        ROW_MODEL = 2'd0,
        ROW_TYPED = 2'd1,
        ROW_QUIET = 2'd2,
        ROW_WRITE = 2'd3
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        reg_addr_t   addr;
        logic        op;
        logic [31:0] data;
        rsp_t        rsp;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [36] = '{
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_START, 32'd0, '{1'b0, 32'sd75098, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd0, '{1'b0, 32'sd121510, 16'd0, 31'd0}},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'h7FFF_FFFF, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'h8000_0000, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd0, '0},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_START, 32'd0, '{1'b0, 32'sd75098, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd12345, '{1'b0, 32'sd121510, 16'd0, 31'd0}},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd12345, '0},
        '{ROW_WRITE, REG_ITERATION_LIMIT, OP_VALUE, 32'd0, '0},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_START, 32'd0, '{1'b0, 32'sd75098, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd5, '{1'b0, 32'sd121510, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd6,
          '{1'b1, 32'sd75098, 16'd0, 31'd196608}},
        '{ROW_QUIET, REG_INTERVAL_LEFT, OP_VALUE, 32'd7, '0},
        '{ROW_WRITE, REG_INTERVAL_LEFT, OP_VALUE, 32'd327680, '0},
        '{ROW_WRITE, REG_INTERVAL_RIGHT, OP_VALUE, 32'd327680, '0},
        '{ROW_WRITE, REG_ITERATION_LIMIT, OP_VALUE, 32'd20, '0},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_START, 32'd0, '{1'b0, 32'sd327680, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'hFFFF_FFFF,
          '{1'b0, 32'sd327680, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd1, '{1'b1, 32'sd327680, 16'd0, 31'd0}},
        '{ROW_WRITE, REG_INTERVAL_LEFT, OP_VALUE, 32'd196608, '0},
        '{ROW_WRITE, REG_INTERVAL_RIGHT, OP_VALUE, 32'd0, '0},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_START, 32'd0, '{1'b0, 32'sd75098, 16'd0, 31'd0}},
        '{ROW_TYPED, REG_INTERVAL_LEFT, OP_VALUE, 32'd3, '{1'b0, 32'sd121510, 16'd0, 31'd0}},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'hFFFF_FFFD, '0},
        '{ROW_WRITE, REG_INTERVAL_LEFT, OP_VALUE, 32'h8000_0000, '0},
        '{ROW_WRITE, REG_INTERVAL_RIGHT, OP_VALUE, 32'h7FFF_FFFF, '0},
        '{ROW_WRITE, REG_TOLERANCE, OP_VALUE, 32'h7FFF_FFFF, '0},
        '{ROW_WRITE, REG_ITERATION_LIMIT, OP_VALUE, 32'h0000_FFFF, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_START, 32'd0, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd1, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd2, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd0, '0},
        '{ROW_WRITE, REG_ITERATION_LIMIT, OP_VALUE, 32'd0, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_START, 32'd0, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd9, '0},
        '{ROW_MODEL, REG_INTERVAL_LEFT, OP_VALUE, 32'd8, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    row_kind_e offer_kind = ROW_MODEL;
    rsp_t      offer_rsp = '0;

    logic signed [31:0] cfg_left = 32'sd0;
    logic signed [31:0] cfg_right = 32'sd196608;
    logic [30:0]        cfg_tol = 31'd7;
    logic [15:0]        cfg_limit = 16'd20;

    logic signed [31:0] pt_outer_left = '0;
    logic signed [31:0] pt_inner_left = '0;
    logic signed [31:0] pt_inner_right = '0;
    logic signed [31:0] pt_outer_right = '0;
    logic [31:0]        span = '0;
    logic [31:0]        stride = '0;
    logic signed [31:0] f_left = '0;
    logic signed [31:0] f_right = '0;
    logic [15:0]        narrowings = '0;
    search_phase_e      search_phase = SRCH_IDLE;
    logic               probe_right = 1'b0;

    rsp_t pending_rsps [$];
    int   errors = 0;
    int   n_cmds = 0;
    int   n_rsps = 0;
    int   n_writes = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 12;
    int   recv_idle_pct = 83;
    bit   hold_req = 1'b0;
    logic signed [31:0] last_objective = '0;

    golden_section_line_search_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] golden_stride(input logic [31:0] w);
        logic [63:0] p;
        p = {32'd0, w} * ETA_Q32 + ROUND_HALF;
        return p[63:32];
    endfunction

    function automatic logic signed [31:0] clamp_point(input longint v);
        if (v > POS_MAX)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < POS_MIN)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void close_search(output rsp_t r);
        r.done_res        = 1'b1;
        r.position        = pt_inner_left;
        r.iterations_used = narrowings;
        r.final_width     = (span > {1'b0, WIDTH_MAX31}) ? WIDTH_MAX31 : span[30:0];
        search_phase      = SRCH_IDLE;
    endfunction

    function automatic bit predict_search(input cmd_t c, output rsp_t r);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] t;
        logic signed [31:0] probe;
        r = '0;
        if (c.opcode == OP_START)
        begin
            lo = cfg_left;
            hi = cfg_right;
            if (lo > hi)
            begin
                lo = cfg_right;
                hi = cfg_left;
            end
            pt_outer_left  = lo;
            pt_outer_right = hi;
            span           = hi - lo;
            stride         = golden_stride(span);
            pt_inner_left  = clamp_point(longint'(lo) + longint'({32'd0, stride}));
            pt_inner_right = clamp_point(longint'(hi) - longint'({32'd0, stride}));
            f_left         = '0;
            f_right        = '0;
            narrowings     = '0;
            probe_right    = 1'b0;
            search_phase   = SRCH_FIRST;
            r.position     = pt_inner_left;
            return 1'b1;
        end
        if (search_phase == SRCH_FIRST)
        begin
            f_left       = c.objective_value;
            probe_right  = 1'b1;
            search_phase = SRCH_RUN;
            r.position   = pt_inner_right;
            return 1'b1;
        end
        if (search_phase != SRCH_RUN)
        begin
            return 1'b0;
        end
        if (probe_right)
        begin
            f_right = c.objective_value;
        end
        else
        begin
            f_left = c.objective_value;
        end
        if (narrowings >= cfg_limit)
        begin
            close_search(r);
            return 1'b1;
        end
        if (f_left < f_right)
        begin
            t              = pt_inner_right;
            pt_inner_right = pt_inner_left;
            pt_inner_left  = clamp_point(longint'(t) - longint'({32'd0, stride}));
            pt_outer_right = t;
            f_right        = f_left;
            probe_right    = 1'b0;
            probe          = pt_inner_left;
        end
        else
        begin
            t              = pt_inner_left;
            pt_inner_left  = pt_inner_right;
            pt_inner_right = clamp_point(longint'(t) + longint'({32'd0, stride}));
            pt_outer_left  = t;
            f_left         = f_right;
            probe_right    = 1'b1;
            probe          = pt_inner_right;
        end
        span   = span - stride;
        stride = golden_stride(span);
        if (span < {1'b0, cfg_tol})
        begin
            close_search(r);
            return 1'b1;
        end
        narrowings = narrowings + 16'd1;
        if (narrowings >= cfg_limit)
        begin
            close_search(r);
            return 1'b1;
        end
        r.position = probe;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 40)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin : check_responses
        rsp_t want;
        rsp_t pred;
        bit   hit;
        if (rsp_valid && !rsp_stall)
        begin
            n_rsps++;
            if (pending_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: response with none pending, expected none, actual %h", $time, rsp);
            end
            else
            begin
                want = pending_rsps.pop_front();
                check_field("done_res", 32'(want.done_res), 32'(rsp.done_res));
                check_field("position", want.position, rsp.position);
                check_field("iterations_used", 32'(want.iterations_used),
                            32'(rsp.iterations_used));
                check_field("final_width", 32'(want.final_width), 32'(rsp.final_width));
            end
        end
        if (cmd_valid && !cmd_stall)
        begin
            n_cmds++;
            hit = predict_search(cmd, pred);
            if (offer_kind == ROW_TYPED)
            begin
                pending_rsps.push_back(offer_rsp);
            end
            else if (offer_kind == ROW_MODEL && hit)
            begin
                pending_rsps.push_back(pred);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : drive_rsp_stall
        int hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_cmd(input cmd_t c, input row_kind_e k, input rsp_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd        <= c;
        offer_kind <= k;
        offer_rsp  <= r;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_addr_t a, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {a, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
        case (a)
            REG_INTERVAL_LEFT:   cfg_left = v;
            REG_INTERVAL_RIGHT:  cfg_right = v;
            REG_TOLERANCE:       cfg_tol = v[30:0];
            REG_ITERATION_LIMIT: cfg_limit = v[15:0];
            default:             ;
        endcase
    endtask

    function automatic cmd_t random_item();
        cmd_t c;
        c.opcode = ($urandom_range(11) == 0) ? OP_START : OP_VALUE;
        case ($urandom_range(7))
            0:       c.objective_value = 32'sh7FFF_FFFF;
            1:       c.objective_value = 32'sh8000_0000;
            2:       c.objective_value = last_objective;
            3:       c.objective_value = 32'($urandom_range(8)) - 32'd4;
            default: c.objective_value = $urandom;
        endcase
        last_objective = c.objective_value;
        return c;
    endfunction

    task automatic run_phase(input int goal, input bit hold);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        tol;
        logic [31:0]        lim;
        cmd_t               first;
        settle();
        case ($urandom_range(5))
            0:       begin lo = $urandom; hi = $urandom; end
            1:       begin lo = 32'sh8000_0000; hi = 32'sh7FFF_FFFF; end
            2:       begin lo = $urandom; hi = lo; end
            default: begin lo = $urandom; hi = lo + $urandom_range(1 << 20); end
        endcase
        if ($urandom_range(1) == 1)
        begin
            {lo, hi} = {hi, lo};
        end
        case ($urandom_range(4))
            0:       tol = 32'd0;
            1:       tol = 32'h7FFF_FFFF;
            2:       tol = $urandom;
            default: tol = $urandom_range(4096);
        endcase
        tol[31] = 1'($urandom_range(1));
        case ($urandom_range(4))
            0:       lim = 32'd0;
            1:       lim = 32'h0000_FFFF;
            2:       lim = $urandom_range(16'hFFFF);
            default: lim = $urandom_range(12);
        endcase
        lim[31:16] = 16'($urandom);
        write_reg(REG_INTERVAL_LEFT, lo);
        write_reg(REG_INTERVAL_RIGHT, hi);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_ITERATION_LIMIT, lim);
        if (hold)
        begin
            hold_req = 1'b1;
        end
        first.opcode          = OP_START;
        first.objective_value = $urandom;
        send_cmd(first, ROW_MODEL, '0);
        repeat (goal - 1)
        begin
            send_cmd(random_item(), ROW_MODEL, '0);
        end
    endtask

    initial
    begin : stimulus
        int   m;
        int   ph;
        cmd_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data);
            end
            else
            begin
                c.opcode          = DIRECTED_ROWS[i].op;
                c.objective_value = DIRECTED_ROWS[i].data;
                send_cmd(c, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].rsp);
            end
        end
        for (m = 0; m < 3; m++)
        begin
            send_idle_pct = (m == 0) ? 12 : (m == 1) ? 83 : 0;
            recv_idle_pct = (m == 0) ? 83 : (m == 1) ? 12 : 0;
            for (ph = 0; ph < 5; ph++)
            begin
                run_phase(PHASE_ITEMS, m == 2 && ph == 0);
            end
        end
        settle();
        $display("Covered %0d commands and %0d responses with %0d register writes,",
                 n_cmds, n_rsps, n_writes);
        $display("under sender-heavy, receiver-heavy and free-running handshake idling.");
        if (errors == 0 && pending_rsps.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
